// File: rtl/fbdraw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbdraw_pkg
// Shared constants, types, command/status structs and the 5x7 font table
// for the framebuffer rectangle and glyph drawer.
// ----------------------------------------------------------------------------
package fbdraw_pkg;

    // Frame geometry
    localparam int FRAME_WIDTH  = 128;
    localparam int FRAME_HEIGHT = 64;
    localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W       = $clog2(FRAME_PIXELS);
    localparam int X_W          = $clog2(FRAME_WIDTH);
    localparam int Y_W          = $clog2(FRAME_HEIGHT);

    // Glyph geometry
    localparam int GLYPH_ROWS   = 7;
    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_PIXELS = GLYPH_ROWS * GLYPH_COLS;
    localparam int GCOL_W       = $clog2(GLYPH_COLS);
    localparam int GSTEP_W      = $clog2(GLYPH_PIXELS);

    // Field widths
    localparam int IN_COORD_W = 9;
    localparam int COORD_W    = 10;   // holds origin plus glyph offset
    localparam int COLOUR_W   = 16;
    localparam int CODE_W     = 8;
    localparam int REQ_W      = 2;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t FRAME_W_C = coord_t'(FRAME_WIDTH);
    localparam coord_t FRAME_H_C = coord_t'(FRAME_HEIGHT);

    // Request type codes
    localparam logic [REQ_W-1:0] REQ_FILL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CHAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic fill_step;
        logic glyph_step;
        logic rd_en;
        logic out_load;
    } fbdraw_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic fill_empty;
        logic fill_last;
        logic glyph_skip;
        logic glyph_last;
    } fbdraw_stat_t;

    // Full glyph bitmap, row 0 in the top bits, leftmost column as MSB of a row
    function automatic logic [GLYPH_PIXELS-1:0] glyph_bitmap(input logic [6:0] code);
        logic [GLYPH_PIXELS-1:0] bits;
        bits = '0;
        case ({1'b0, code})
            "A": bits = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "B": bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            "C": bits = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            "D": bits = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
            "E": bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "F": bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            "G": bits = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
            "H": bits = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "I": bits = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "J": bits = {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
            "K": bits = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            "L": bits = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            "M": bits = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            "N": bits = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            "O": bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "P": bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            "Q": bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            "R": bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            "S": bits = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "T": bits = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "U": bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "V": bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            "W": bits = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
            "X": bits = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            "Y": bits = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            "Z": bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            "0": bits = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            "1": bits = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "2": bits = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            "3": bits = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
            "4": bits = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            "5": bits = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
            "6": bits = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            "7": bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            "8": bits = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            "9": bits = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
            ".": bits = {5'h06, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
            ":": bits = {5'h0A, 5'h00, 5'h0A, 5'h00, 5'h00, 5'h00, 5'h00};
            "-": bits = {5'h1F, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
            ">": bits = {5'h02, 5'h04, 5'h08, 5'h04, 5'h02, 5'h00, 5'h00};
            default: bits = '0;
        endcase
        return bits;
    endfunction

endpackage
`default_nettype wire

// File: rtl/fbdraw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbdraw_datapath
// Coordinate walkers, clipping, glyph shift register, frame memory and
// result register of the drawer.
// ----------------------------------------------------------------------------
module fbdraw_datapath
    import fbdraw_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire fbdraw_cmd_t                  cmd,
    output fbdraw_stat_t                      stat,
    input  wire logic signed [IN_COORD_W-1:0] left_x,
    input  wire logic signed [IN_COORD_W-1:0] top_y,
    input  wire logic signed [IN_COORD_W-1:0] right_x,
    input  wire logic signed [IN_COORD_W-1:0] bottom_y,
    input  wire logic        [CODE_W-1:0]     char_code,
    input  wire logic        [COLOUR_W-1:0]   colour,
    input  wire logic        [REQ_W-1:0]      req_type,
    output logic             [COLOUR_W-1:0]   pixel_value
);

    coord_t cur_x_reg, cur_x_next;
    coord_t cur_y_reg, cur_y_next;
    coord_t x_start_reg, x_start_next;
    coord_t x_end_reg, x_end_next;
    coord_t y_end_reg, y_end_next;
    logic [COLOUR_W-1:0]     colour_reg, colour_next;
    logic [GLYPH_PIXELS-1:0] glyph_reg, glyph_next;
    logic [GCOL_W-1:0]       gcol_reg, gcol_next;
    logic [GSTEP_W-1:0]      gstep_reg, gstep_next;
    logic                    rd_on_reg;
    logic [COLOUR_W-1:0]     rd_data_reg;
    logic [COLOUR_W-1:0]     pixel_value_reg;

    logic [COLOUR_W-1:0]     frame_mem [FRAME_PIXELS];

    coord_t lx_s, ty_s, rx_s, by_s;
    coord_t xa, ya, xb, yb;
    logic [GLYPH_PIXELS-1:0] glyph_rom_bits;
    logic                    on_buf;
    logic                    wr_en;
    logic [ADDR_W-1:0]       addr;
    logic [X_W-1:0]          x_idx;
    logic [Y_W-1:0]          y_idx;
    logic                    row_end;

    // sign extend and clip the request corners
    always_comb
    begin
        lx_s = coord_t'(left_x);
        ty_s = coord_t'(top_y);
        rx_s = coord_t'(right_x);
        by_s = coord_t'(bottom_y);
        xa   = (lx_s < 0) ? '0 : lx_s;
        ya   = (ty_s < 0) ? '0 : ty_s;
        xb   = (rx_s > FRAME_W_C) ? FRAME_W_C : rx_s;
        yb   = (by_s > FRAME_H_C) ? FRAME_H_C : by_s;
    end

    assign glyph_rom_bits = glyph_bitmap(char_code[6:0]);

    // status toward the controller
    always_comb
    begin
        row_end         = (cur_x_reg + coord_t'(1)) == x_end_reg;
        stat.fill_empty = (xb <= xa) || (yb <= ya);
        stat.fill_last  = row_end && ((cur_y_reg + coord_t'(1)) == y_end_reg);
        stat.glyph_skip = char_code[CODE_W-1] ||
                          (glyph_rom_bits[GLYPH_PIXELS-1 -: GLYPH_COLS] == '0);
        stat.glyph_last = gstep_reg == GSTEP_W'(GLYPH_PIXELS - 1);
    end

    // pixel address and clipping of the current position
    always_comb
    begin
        on_buf = (cur_x_reg >= 0) && (cur_x_reg < FRAME_W_C) &&
                 (cur_y_reg >= 0) && (cur_y_reg < FRAME_H_C);
        x_idx  = cur_x_reg[X_W-1:0];
        y_idx  = cur_y_reg[Y_W-1:0];
        addr   = ADDR_W'(ADDR_W'(y_idx) * ADDR_W'(FRAME_WIDTH)) + ADDR_W'(x_idx);
        wr_en  = cmd.fill_step || (cmd.glyph_step && glyph_reg[GLYPH_PIXELS-1] && on_buf);
    end

    // next-state of the walkers
    always_comb
    begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        x_start_next = x_start_reg;
        x_end_next   = x_end_reg;
        y_end_next   = y_end_reg;
        colour_next  = colour_reg;
        glyph_next   = glyph_reg;
        gcol_next    = gcol_reg;
        gstep_next   = gstep_reg;
        if (cmd.load)
        begin
            cur_x_next   = (req_type == REQ_FILL) ? xa : lx_s;
            cur_y_next   = (req_type == REQ_FILL) ? ya : ty_s;
            x_start_next = (req_type == REQ_FILL) ? xa : lx_s;
            x_end_next   = xb;
            y_end_next   = yb;
            colour_next  = colour;
            glyph_next   = glyph_rom_bits;
            gcol_next    = '0;
            gstep_next   = '0;
        end
        else if (cmd.fill_step)
        begin
            if (row_end)
            begin
                cur_x_next = x_start_reg;
                cur_y_next = cur_y_reg + coord_t'(1);
            end
            else
            begin
                cur_x_next = cur_x_reg + coord_t'(1);
            end
        end
        else if (cmd.glyph_step)
        begin
            glyph_next = {glyph_reg[GLYPH_PIXELS-2:0], 1'b0};
            gstep_next = gstep_reg + GSTEP_W'(1);
            if (gcol_reg == GCOL_W'(GLYPH_COLS - 1))
            begin
                gcol_next  = '0;
                cur_x_next = x_start_reg;
                cur_y_next = cur_y_reg + coord_t'(1);
            end
            else
            begin
                gcol_next  = gcol_reg + GCOL_W'(1);
                cur_x_next = cur_x_reg + coord_t'(1);
            end
        end
    end

    // walker registers; reset value sets up the full-frame clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            x_start_reg <= '0;
            x_end_reg   <= FRAME_W_C;
            y_end_reg   <= FRAME_H_C;
            colour_reg  <= '0;
            glyph_reg   <= '0;
            gcol_reg    <= '0;
            gstep_reg   <= '0;
        end
        else
        begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            x_start_reg <= x_start_next;
            x_end_reg   <= x_end_next;
            y_end_reg   <= y_end_next;
            colour_reg  <= colour_next;
            glyph_reg   <= glyph_next;
            gcol_reg    <= gcol_next;
            gstep_reg   <= gstep_next;
        end
    end

    // frame memory: one port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[addr] <= colour_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= frame_mem[addr];
            rd_on_reg   <= on_buf;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pixel_value_reg <= rd_on_reg ? rd_data_reg : '0;
        end
    end

    assign pixel_value = pixel_value_reg;

endmodule
`default_nettype wire

// File: rtl/fbdraw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbdraw_ctrl
// Request sequencer: clearing pass, fill and glyph walks, pixel read and
// the result handshake.
// ----------------------------------------------------------------------------
module fbdraw_ctrl
    import fbdraw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic [REQ_W-1:0]  req_type,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output fbdraw_cmd_t            cmd,
    input  wire fbdraw_stat_t      stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_GLYPH,
        ST_READ,
        ST_READ_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   accept;
    logic   slot_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    case (req_type)
                        REQ_FILL: state_next = stat.fill_empty ? ST_IDLE : ST_FILL;
                        REQ_CHAR: state_next = stat.glyph_skip ? ST_IDLE : ST_GLYPH;
                        REQ_READ: state_next = ST_READ;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_GLYPH:
            begin
                cmd.glyph_step = 1'b1;
                if (stat.glyph_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_READ_DONE;
            end
            ST_READ_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register; reset starts the clearing pass as a full-frame fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // at most one datapath action per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.fill_step, cmd.glyph_step, cmd.rd_en, cmd.out_load}))
        else $error("fbdraw_ctrl: more than one datapath command");

    // a result never overwrites one still waiting
    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> slot_free)
        else $error("fbdraw_ctrl: result loaded over pending result");

    // no new transaction while the frame memory is being walked
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fill_step || cmd.glyph_step || cmd.rd_en) |-> !req_ready)
        else $error("fbdraw_ctrl: request ready during a walk");

    // ST_READ_DONE, which loads the result, follows in the cycle after the memory read
    a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> (state_reg == ST_READ_DONE))
        else $error("fbdraw_ctrl: read not followed by capture");

endmodule
`default_nettype wire

// File: rtl/framebuffer_rect_and_glyph_drawer.sv
`default_nettype none
// Fill writes each clipped pixel in turn and a glyph walks every position of its
// bitmap (one frame memory write port, one pixel per cycle); a read loads the
// result once the result slot is free. Empty fills and undrawn glyphs need no walk.
// One transaction at a time; a waiting result does not block the next request.
// Reset: the frame memory is cleared to black by a full-frame fill pass with
// req_ready low.
// ----------------------------------------------------------------------------
// framebuffer_rect_and_glyph_drawer
// Drawing engine over an internal RGB565 framebuffer: rectangle fill,
// 5x7 glyph draw and pixel readback.
// ----------------------------------------------------------------------------
module framebuffer_rect_and_glyph_drawer
    import fbdraw_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire logic        [REQ_W-1:0]      req_type,
    input  wire logic signed [IN_COORD_W-1:0] left_x,
    input  wire logic signed [IN_COORD_W-1:0] top_y,
    input  wire logic signed [IN_COORD_W-1:0] right_x,
    input  wire logic signed [IN_COORD_W-1:0] bottom_y,
    input  wire logic        [CODE_W-1:0]     char_code,
    input  wire logic        [COLOUR_W-1:0]   colour,
    output logic                              rsp_valid,
    input  wire logic                         rsp_ready,
    output logic             [COLOUR_W-1:0]   pixel_value
);

    fbdraw_cmd_t  cmd;
    fbdraw_stat_t stat;

    // sequencer
    fbdraw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // walkers, frame memory and result register
    fbdraw_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .left_x      (left_x),
        .top_y       (top_y),
        .right_x     (right_x),
        .bottom_y    (bottom_y),
        .char_code   (char_code),
        .colour      (colour),
        .req_type    (req_type),
        .pixel_value (pixel_value)
    );

endmodule
`default_nettype wire

// File: dv/tb_framebuffer_rect_and_glyph_drawer.sv
// ----------------------------------------------------------------------------
// tb_framebuffer_rect_and_glyph_drawer
// Self-checking bench for the rectangle/glyph drawer. A mirror of the
// framebuffer is painted for every accepted request, and each read-back is
// compared with the mirror. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_framebuffer_rect_and_glyph_drawer;
    import fbdraw_pkg::*;

    // Request type that the block ignores
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int               SMALL_FILL = 12;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         req_valid;
    logic                         req_ready;
    logic        [REQ_W-1:0]      req_type;
    logic signed [IN_COORD_W-1:0] left_x;
    logic signed [IN_COORD_W-1:0] top_y;
    logic signed [IN_COORD_W-1:0] right_x;
    logic signed [IN_COORD_W-1:0] bottom_y;
    logic        [CODE_W-1:0]     char_code;
    logic        [COLOUR_W-1:0]   colour;
    logic                         rsp_valid;
    logic                         rsp_ready;
    logic        [COLOUR_W-1:0]   pixel_value;

    // Mirror of the frame and the read-backs still owed by the block
    logic [COLOUR_W-1:0] frame_mirror [FRAME_PIXELS];
    logic [COLOUR_W-1:0] expected_pixels [$];

    int     error_count  = 0;
    longint cycle_count  = 0;
    longint work_budget  = 0;
    int     hold_request = 0;
    bit     src_no_idle  = 1'b0;
    bit     sink_no_idle = 1'b0;
    string  glyph_set    = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.:->";

    framebuffer_rect_and_glyph_drawer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .left_x      (left_x),
        .top_y       (top_y),
        .right_x     (right_x),
        .bottom_y    (bottom_y),
        .char_code   (char_code),
        .colour      (colour),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .pixel_value (pixel_value)
    );

    always #10 clk = ~clk;

    // 5x7 font, row 0 in the top bits, leftmost column first
    function automatic logic [GLYPH_PIXELS-1:0] font_bits(input logic [CODE_W-1:0] ch);
        case (ch)
            "A": return {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "B": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            "C": return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            "D": return {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
            "E": return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "F": return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            "G": return {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
            "H": return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "I": return {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "J": return {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
            "K": return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            "L": return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            "M": return {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            "N": return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            "O": return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "P": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            "Q": return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            "R": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            "S": return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "T": return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "U": return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "V": return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            "W": return {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
            "X": return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            "Y": return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            "Z": return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            "0": return {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            "1": return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "2": return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            "3": return {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
            "4": return {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            "5": return {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
            "6": return {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            "7": return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            "8": return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            "9": return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
            ".": return {5'h06, 30'h0};
            ":": return {5'h0A, 5'h00, 5'h0A, 20'h0};
            "-": return {5'h1F, 30'h0};
            ">": return {5'h02, 5'h04, 5'h08, 5'h04, 5'h02, 10'h0};
            default: return '0;
        endcase
    endfunction

    function automatic bit on_frame(input int x, input int y);
        return x >= 0 && x < FRAME_WIDTH && y >= 0 && y < FRAME_HEIGHT;
    endfunction

    // Paint one request into the mirror, queue the read-back if any.
    // Returns the number of pixel steps the block walks for it.
    function automatic int paint_request(input logic [REQ_W-1:0] kind,
                                         input logic signed [IN_COORD_W-1:0] lx, ty, rx, by,
                                         input logic [CODE_W-1:0] ch,
                                         input logic [COLOUR_W-1:0] col);
        int x0, y0, x1, y1, cost;
        logic [GLYPH_PIXELS-1:0] bits;
        x0   = lx;
        y0   = ty;
        x1   = rx;
        y1   = by;
        cost = 0;
        bits = font_bits(ch);
        case (kind)
            REQ_FILL:
            begin
                // clip to the frame; an empty span leaves the loops idle
                if (x0 < 0) x0 = 0;
                if (y0 < 0) y0 = 0;
                if (x1 > FRAME_WIDTH) x1 = FRAME_WIDTH;
                if (y1 > FRAME_HEIGHT) y1 = FRAME_HEIGHT;
                for (int y = y0; y < y1; y++)
                begin
                    for (int x = x0; x < x1; x++)
                    begin
                        frame_mirror[y * FRAME_WIDTH + x] = col;
                        cost++;
                    end
                end
            end
            REQ_CHAR:
            begin
                // space, high codes and blank top rows draw nothing
                if (ch != " " && !ch[CODE_W-1]
                    && bits[GLYPH_PIXELS-1 -: GLYPH_COLS] != '0)
                begin
                    for (int r = 0; r < GLYPH_ROWS; r++)
                    begin
                        for (int k = 0; k < GLYPH_COLS; k++)
                        begin
                            if (bits[GLYPH_PIXELS-1 - r * GLYPH_COLS - k]
                                && on_frame(x0 + k, y0 + r))
                                frame_mirror[(y0 + r) * FRAME_WIDTH + x0 + k] = col;
                        end
                    end
                    cost = GLYPH_PIXELS;
                end
            end
            REQ_READ:
                expected_pixels.push_back(on_frame(x0, y0) ?
                                          frame_mirror[y0 * FRAME_WIDTH + x0] : '0);
            default: ;
        endcase
        return cost;
    endfunction

    function automatic int draw_idle(input bit quiet);
        if (quiet || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Offer one request and hold it until the block takes it; valid stays
    // high on return so back-to-back requests need no idle between them.
    // Coordinates, code and colour are cut to their port widths here.
    task automatic send_req(input logic [REQ_W-1:0] kind,
                            input int lx, ty, rx, by,
                            input int ch,
                            input int col);
        logic signed [IN_COORD_W-1:0] lx_f, ty_f, rx_f, by_f;
        logic        [CODE_W-1:0]     ch_f;
        logic        [COLOUR_W-1:0]   col_f;
        int                           gap;
        lx_f  = IN_COORD_W'(lx);
        ty_f  = IN_COORD_W'(ty);
        rx_f  = IN_COORD_W'(rx);
        by_f  = IN_COORD_W'(by);
        ch_f  = CODE_W'(ch);
        col_f = COLOUR_W'(col);
        gap   = draw_idle(src_no_idle);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        left_x    <= lx_f;
        top_y     <= ty_f;
        right_x   <= rx_f;
        bottom_y  <= by_f;
        char_code <= ch_f;
        colour    <= col_f;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        work_budget += 40 + paint_request(kind, lx_f, ty_f, rx_f, by_f, ch_f, col_f);
    endtask

    task automatic send_read(input int x, input int y);
        send_req(REQ_READ, x, y, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
    endtask

    // Random request, mostly well-formed around the visible frame
    task automatic send_random_item();
        logic [REQ_W-1:0] kind;
        int               lx, ty, rx, by;
        int               ch;
        int               pick;
        pick = $urandom_range(0, 99);
        lx   = $urandom;
        ty   = $urandom;
        rx   = $urandom;
        by   = $urandom;
        ch   = $urandom;
        if (pick < 30)
        begin
            kind = REQ_FILL;
            if ($urandom_range(0, 9) != 0)
            begin
                lx = $urandom_range(0, FRAME_WIDTH + 15) - 8;
                ty = $urandom_range(0, FRAME_HEIGHT + 15) - 8;
                rx = lx + $urandom_range(0, SMALL_FILL) - 1;
                by = ty + $urandom_range(0, SMALL_FILL) - 1;
            end
        end
        else if (pick < 62)
        begin
            kind = REQ_CHAR;
            if ($urandom_range(0, 3) != 0)
                ch = glyph_set[$urandom_range(0, glyph_set.len() - 1)];
            if ($urandom_range(0, 9) != 0)
            begin
                lx = $urandom_range(0, FRAME_WIDTH + 11) - 6;
                ty = $urandom_range(0, FRAME_HEIGHT + 11) - 8;
            end
        end
        else if (pick < 96)
        begin
            kind = REQ_READ;
            if ($urandom_range(0, 6) != 0)
            begin
                lx = $urandom_range(0, FRAME_WIDTH - 1);
                ty = $urandom_range(0, FRAME_HEIGHT - 1);
            end
        end
        else
            kind = REQ_UNUSED;
        send_req(kind, lx, ty, rx, by, ch, $urandom);
    endtask

    // Extremes, clipping, empty rectangles, undrawn glyphs, unused type
    task automatic test_directed();
        send_read(0, 0);
        send_read(FRAME_WIDTH - 1, FRAME_HEIGHT - 1);
        send_read(-1, 0);
        send_read(FRAME_WIDTH, FRAME_HEIGHT - 1);
        send_read(0, FRAME_HEIGHT);
        send_read(-256, -256);
        send_read(255, 255);
        send_req(REQ_FILL, -256, -256, 255, 255, 8'h00, 16'hFFFF);
        send_read(FRAME_WIDTH - 1, 0);
        send_req(REQ_FILL, 20, 10, 20, 30, 8'h00, 16'h0000);
        send_req(REQ_FILL, 20, 10, 40, 10, 8'h00, 16'h0000);
        send_req(REQ_FILL, 40, 30, 20, 10, 8'h00, 16'h0000);
        send_req(REQ_FILL, 2, 2, 12, 12, 8'hFF, 16'h0000);
        send_req(REQ_CHAR, 3, 3, 0, 0, "A", 16'hF800);
        send_read(5, 3);
        send_read(3, 3);
        send_req(REQ_CHAR, 2, 2, 0, 0, " ", 16'h07E0);
        send_req(REQ_CHAR, 2, 2, 0, 0, 8'hC8, 16'h07E0);
        send_req(REQ_CHAR, 2, 2, 0, 0, "a", 16'h07E0);
        send_req(REQ_UNUSED, 2, 2, 12, 12, "B", 16'h07E0);
        send_read(2, 2);
        send_req(REQ_CHAR, FRAME_WIDTH - 3, FRAME_HEIGHT - 4, 0, 0, "W", 16'h001F);
        send_read(FRAME_WIDTH - 1, FRAME_HEIGHT - 1);
        send_req(REQ_CHAR, -2, -3, 0, 0, "8", 16'h1234);
        send_read(0, 0);
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 450; i++)
            send_random_item();
    endtask

    // Long response stall while reads keep coming: the block must back up
    task automatic test_output_backpressure();
        hold_request = 300;
        work_budget += 300;
        src_no_idle  = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            if (i % 4 == 3)
                send_req(REQ_FILL, $urandom_range(0, 60), $urandom_range(0, 30),
                         $urandom_range(60, 70), $urandom_range(30, 36), 8'h00, $urandom);
            else
                send_read($urandom_range(0, FRAME_WIDTH - 1), $urandom_range(0, FRAME_HEIGHT - 1));
        end
        src_no_idle = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        for (int i = 0; i < 15; i++)
            send_random_item();
        wait_drained();
        for (int i = 0; i < 15; i++)
            send_random_item();
    endtask

    task automatic test_full_rate();
        src_no_idle  = 1'b1;
        sink_no_idle = 1'b1;
        for (int i = 0; i < 60; i++)
            send_random_item();
        src_no_idle  = 1'b0;
        sink_no_idle = 1'b0;
    endtask

    // Response side: random stall before each transaction, or a long hold
    initial
    begin : response_sink
        int stall_left;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        stall_left = draw_idle(sink_no_idle);
        forever
        begin
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            rsp_ready <= (stall_left == 0);
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                stall_left = draw_idle(sink_no_idle);
            else if (stall_left > 0)
                stall_left--;
        end
    end

    // Compare each read-back with the oldest owed pixel
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got pixel_value %h",
                         $time, pixel_value);
                error_count++;
            end
            else if (pixel_value !== expected_pixels[0])
            begin
                $display("%0t: pixel_value mismatch, expected %h, got %h",
                         $time, expected_pixels[0], pixel_value);
                error_count++;
                void'(expected_pixels.pop_front());
            end
            else
                void'(expected_pixels.pop_front());
        end
    end

    // Watchdog: clear pass plus a generous multiple of the work sent so far
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 40000 + 4 * work_budget)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_type  <= REQ_FILL;
        left_x    <= '0;
        top_y     <= '0;
        right_x   <= '0;
        bottom_y  <= '0;
        char_code <= '0;
        colour    <= '0;
        foreach (frame_mirror[i])
            frame_mirror[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_traffic();
        test_output_backpressure();
        test_pause_until_drained();
        test_full_rate();

        wait_drained();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/fbdraw_pkg.sv
rtl/fbdraw_datapath.sv
rtl/fbdraw_ctrl.sv
rtl/framebuffer_rect_and_glyph_drawer.sv
dv/tb_framebuffer_rect_and_glyph_drawer.sv
